/* src/capture_ring_buffer_macros.svh */
// Assertion macros for the capture ring buffer.
`ifndef CAPTURE_RING_BUFFER_MACROS_SVH
`define CAPTURE_RING_BUFFER_MACROS_SVH
`ifndef ASSERT_OFF
`define CRB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CRB_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CRB_ASSERT(name, prop, msg)
`define CRB_ASSERT_RST(name, prop, msg)
`endif
`endif

/* src/crb_pkg.sv */
`default_nettype none
package crb_pkg;

  localparam logic [3:0] OP_COMMIT   = 4'd0;
  localparam logic [3:0] OP_READ_POS = 4'd1;
  localparam logic [3:0] OP_READ_SEQ = 4'd2;
  localparam logic [3:0] OP_CLEAR    = 4'd3;
  localparam logic [3:0] OP_ADD      = 4'd4;
  localparam logic [3:0] OP_ANNOUNCE = 4'd5;
  localparam logic [3:0] OP_WITHDRAW = 4'd6;
  localparam logic [3:0] OP_ATTACH   = 4'd7;
  localparam logic [3:0] OP_PUBLISH  = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_CAP  = 1'b0;
  localparam logic REG_SNAP = 1'b1;

  localparam logic [10:0] CAP_RESET  = 11'd1024;
  localparam logic [15:0] SNAP_RESET = 16'hFFFF;

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_SUM1  = 13'b0000000000100,
    S_SUM2  = 13'b0000000001000,
    S_SUM3  = 13'b0000000010000,
    S_ADDR  = 13'b0000000100000,
    S_DIVGO = 13'b0000001000000,
    S_DIV   = 13'b0000010000000,
    S_RD    = 13'b0000100000000,
    S_CHK   = 13'b0001000000000,
    S_EXEC  = 13'b0010000000000,
    S_MAYW  = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } crb_state_t;

  typedef struct packed {
    logic latch;
    logic sum1;
    logic sum2;
    logic sum3;
    logic addr;
    logic div_go;
    logic rd;
    logic chk;
    logic exec;
    logic mayw;
    logic out_load;
    logic clr;
  } crb_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       clr_last;
    logic [3:0] op;
  } crb_sts_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [15:0] len;
    logic [31:0] info;
  } crb_entry_t;

endpackage
`default_nettype wire

/* src/crb_mod.sv */
`default_nettype none
module crb_mod
  import crb_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [CW-1:0] divisor,
  output logic               done,
  output logic [AW-1:0]      rem
);

  localparam int XW = CW + 4;

  logic          active_r;
  logic          done_r;
  logic [3:0]    step_r;
  logic [63:0]   sh_r;
  logic [CW-1:0] div_r;
  logic [CW-1:0] rem_r;
  logic [XW-1:0] x_nxt;

  always_comb begin
    x_nxt = {rem_r, sh_r[63:60]};
    for (int k = 3; k >= 0; k--) begin
      if (x_nxt >= (XW'(div_r) << k)) begin
        x_nxt = x_nxt - (XW'(div_r) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        step_r   <= '0;
      end else if (active_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'd15) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (active_r) begin
      sh_r  <= sh_r << 4;
      rem_r <= CW'(x_nxt);
    end
  end

  assign done = done_r;
  assign rem  = AW'(rem_r);

endmodule
`default_nettype wire

/* src/crb_ctrl.sv */
`default_nettype none
`include "capture_ring_buffer_macros.svh"
module crb_ctrl
  import crb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output crb_cmd_t      cmd,
  input  wire crb_sts_t sts
);

  crb_state_t state_r, state_nxt;
  logic       post_r, post_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       mem_op;

  assign mem_op = (sts.op == OP_COMMIT) || (sts.op == OP_READ_POS) ||
                  (sts.op == OP_READ_SEQ);

  always_comb begin
    state_nxt = state_r;
    post_nxt  = post_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          post_nxt  = 1'b0;
          state_nxt = S_SUM1;
        end
      end
      S_SUM1: begin
        cmd.sum1  = 1'b1;
        state_nxt = S_SUM2;
      end
      S_SUM2: begin
        cmd.sum2  = 1'b1;
        state_nxt = S_SUM3;
      end
      S_SUM3: begin
        cmd.sum3 = 1'b1;
        if (post_r) state_nxt = S_MAYW;
        else if (mem_op) state_nxt = S_ADDR;
        else state_nxt = S_EXEC;
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.op == OP_COMMIT) state_nxt = S_EXEC;
          else state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        post_nxt  = 1'b1;
        state_nxt = S_SUM1;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        post_nxt  = 1'b1;
        state_nxt = S_SUM1;
      end
      S_MAYW: begin
        cmd.mayw  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      post_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      post_r      <= post_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `CRB_ASSERT(a_done_in_wait, sts.div_done |-> (state_r == S_DIV), "divider done outside wait")
  `CRB_ASSERT(a_result_from_out, $rose(out_valid_r) |-> $past(state_r == S_OUT), "stray result")
  `CRB_ASSERT_RST(a_reset_sweep, !rst_n |=> in_stall, "input taken during memory sweep")

endmodule
`default_nettype wire

/* src/crb_dp.sv */
`default_nettype none
module crb_dp
  import crb_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int MAX_CONSUMERS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire crb_cmd_t    cmd,
  output crb_sts_t         sts,
  input  wire logic [3:0]  in_op,
  input  wire logic [1:0]  in_consumer_id,
  input  wire logic [9:0]  in_position,
  input  wire logic [63:0] in_sequence_req,
  input  wire logic [31:0] in_record_info,
  input  wire logic [15:0] in_record_length,
  input  wire logic [10:0] cfg_cap,
  input  wire logic [15:0] cfg_snap,
  output logic [1:0]       out_status,
  output logic [31:0]      out_record_info_out,
  output logic [15:0]      out_record_length_out,
  output logic [63:0]      out_record_sequence,
  output logic [1:0]       out_assigned_consumer,
  output logic [10:0]      out_stored_count,
  output logic [63:0]      out_oldest_sequence,
  output logic [63:0]      out_total_committed,
  output logic             out_may_write,
  output logic [3:0]       out_wake_mask,
  output logic [63:0]      out_wakeups_sent
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(MAX_CONSUMERS + 1);

  crb_entry_t mem [DEPTH];
  crb_entry_t rd_r;
  crb_entry_t wdata;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] slot;
  logic          div_done;

  logic [CW-1:0] cap_r;
  logic [63:0]   total_r, floor_r, wakeups_r;
  logic [NW-1:0] ccount_r;
  logic [MAX_CONSUMERS-1:0] waiting_r, attached_r;
  logic [63:0]   cpos_r [MAX_CONSUMERS];

  logic [3:0]    op_r;
  logic [1:0]    id_r;
  logic [9:0]    pos_r;
  logic [63:0]   seq_r;
  logic [31:0]   info_in_r;
  logic [15:0]   len_in_r;

  logic [63:0]   base_r, oldest_r, tgt_r;
  logic [CW-1:0] cnt_r;
  logic          win_r;
  logic          mayw_r;

  logic [1:0]    status_r, assigned_r;
  logic [31:0]   info_res_r;
  logic [15:0]   len_res_r;
  logic [63:0]   seq_res_r;
  logic [3:0]    mask_r;

  logic [MAX_CONSUMERS-1:0] woken;
  logic [MAX_CONSUMERS-1:0] sel;
  logic [4:0]    nwake;
  logic          mayw_nxt;
  logic          is_commit;
  logic [31:0]   cap_ext;

  crb_mod #(.DEPTH(DEPTH)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (tgt_r),
    .divisor  (cap_r),
    .done     (div_done),
    .rem      (slot)
  );

  assign is_commit = (op_r == OP_COMMIT);
  assign cap_ext   = {21'b0, cfg_cap};

  always_comb begin
    woken = '0;
    sel   = '0;
    nwake = '0;
    for (int i = 0; i < MAX_CONSUMERS; i++) begin
      if (i < 32'(ccount_r)) begin
        sel[i] = (32'(id_r) == i);
        if (waiting_r[i]) begin
          woken[i] = 1'b1;
          nwake    = nwake + 5'd1;
        end
      end
    end
  end

  always_comb begin
    mayw_nxt = 1'b1;
    for (int i = 0; i < MAX_CONSUMERS; i++) begin
      if (i < 32'(ccount_r) && attached_r[i] && cpos_r[i] < total_r) begin
        if ((total_r - cpos_r[i]) >= (64'(cap_r) - 64'd1)) mayw_nxt = 1'b0;
      end
    end
  end

  assign mem_we = cmd.clr || (cmd.exec && is_commit);
  assign waddr  = cmd.clr ? clr_idx_r : slot;
  always_comb begin
    wdata       = '0;
    wdata.valid = !cmd.clr;
    wdata.tag   = total_r;
    wdata.len   = len_in_r;
    wdata.info  = info_in_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (cmd.rd) rd_r <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (cap_ext < 32'd2) cap_r <= CW'(2);
    else if (cap_ext > DEPTH) cap_r <= CW'(DEPTH);
    else cap_r <= CW'(cap_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      total_r    <= '0;
      floor_r    <= '0;
      wakeups_r  <= '0;
      ccount_r   <= NW'(1);
      waiting_r  <= '0;
      attached_r <= '0;
      for (int i = 0; i < MAX_CONSUMERS; i++) cpos_r[i] <= '0;
    end else begin
      if (cmd.clr) clr_idx_r <= clr_idx_r + AW'(1);
      if (cmd.exec) begin
        case (op_r)
          OP_COMMIT: begin
            total_r   <= total_r + 64'd1;
            waiting_r <= waiting_r & ~woken;
            wakeups_r <= wakeups_r + 64'(nwake);
          end
          OP_CLEAR: floor_r <= total_r;
          OP_ADD: begin
            if (32'(ccount_r) < MAX_CONSUMERS) ccount_r <= ccount_r + NW'(1);
          end
          OP_ANNOUNCE: waiting_r <= waiting_r | sel;
          OP_WITHDRAW: waiting_r <= waiting_r & ~sel;
          OP_ATTACH, OP_PUBLISH: begin
            attached_r <= attached_r | sel;
            for (int i = 0; i < MAX_CONSUMERS; i++) begin
              if (sel[i]) cpos_r[i] <= (op_r == OP_PUBLISH) ? seq_r : 64'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_op;
      id_r       <= in_consumer_id;
      pos_r      <= in_position;
      seq_r      <= in_sequence_req;
      info_in_r  <= in_record_info;
      len_in_r   <= in_record_length;
      status_r   <= ST_OK;
      assigned_r <= '0;
      info_res_r <= '0;
      len_res_r  <= '0;
      seq_res_r  <= '0;
      mask_r     <= '0;
    end
    if (cmd.sum1) base_r <= (total_r > 64'(cap_r)) ? total_r - 64'(cap_r) : 64'd0;
    if (cmd.sum2) oldest_r <= (floor_r > base_r) ? floor_r : base_r;
    if (cmd.sum3) cnt_r <= (oldest_r >= total_r) ? '0 : CW'(total_r - oldest_r);
    if (cmd.addr) begin
      case (op_r)
        OP_READ_POS: begin
          tgt_r <= oldest_r + {54'b0, pos_r};
          win_r <= 32'(pos_r) < 32'(cnt_r);
        end
        OP_READ_SEQ: begin
          tgt_r <= seq_r;
          win_r <= (seq_r >= oldest_r) && (seq_r < total_r);
        end
        default: begin
          tgt_r <= total_r;
          win_r <= 1'b0;
        end
      endcase
    end
    if (cmd.chk) begin
      if (win_r && rd_r.valid && rd_r.tag == tgt_r) begin
        info_res_r <= rd_r.info;
        len_res_r  <= (rd_r.len > cfg_snap) ? cfg_snap : rd_r.len;
        seq_res_r  <= tgt_r;
      end else begin
        status_r <= ST_MISS;
      end
    end
    if (cmd.exec && is_commit) mask_r <= 4'(woken);
    if (cmd.exec && op_r == OP_ADD) begin
      if (32'(ccount_r) < MAX_CONSUMERS) assigned_r <= 2'(ccount_r);
      else status_r <= ST_FULL;
    end
    if (cmd.mayw) mayw_r <= mayw_nxt;
    if (cmd.out_load) begin
      out_status            <= status_r;
      out_record_info_out   <= info_res_r;
      out_record_length_out <= len_res_r;
      out_record_sequence   <= seq_res_r;
      out_assigned_consumer <= assigned_r;
      out_stored_count      <= 11'(cnt_r);
      out_oldest_sequence   <= oldest_r;
      out_total_committed   <= total_r;
      out_may_write         <= mayw_r;
      out_wake_mask         <= mask_r;
      out_wakeups_sent      <= wakeups_r;
    end
  end

  assign sts.div_done = div_done;
  assign sts.clr_last = (clr_idx_r == AW'(DEPTH - 1));
  assign sts.op       = op_r;

endmodule
`default_nettype wire

/* src/capture_ring_buffer.sv */
`default_nettype none
// Channel   Ports                          Handshake
// input     in_op .. in_record_length      in_valid / in_stall
// result    out_status .. out_wakeups_sent out_valid / out_stall
// config    psel penable pwrite paddr ...  APB write, pready tied high
//
// Clear, wait, withdraw, attach, publish and add sum, execute, sum again and load.
// Commits and reads first find the slot with the 16-step radix-16 slot modulo.
// After reset the tag memory is swept; in_stall is high meanwhile.
// A finished result waits in the output register while the next transaction starts.
// A stalled result holds the block only when the following result is ready.
module capture_ring_buffer
  import crb_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int MAX_CONSUMERS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_op,
  input  wire logic [1:0]  in_consumer_id,
  input  wire logic [9:0]  in_position,
  input  wire logic [63:0] in_sequence_req,
  input  wire logic [31:0] in_record_info,
  input  wire logic [15:0] in_record_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_record_info_out,
  output logic [15:0]      out_record_length_out,
  output logic [63:0]      out_record_sequence,
  output logic [1:0]       out_assigned_consumer,
  output logic [10:0]      out_stored_count,
  output logic [63:0]      out_oldest_sequence,
  output logic [63:0]      out_total_committed,
  output logic             out_may_write,
  output logic [3:0]       out_wake_mask,
  output logic [63:0]      out_wakeups_sent,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  crb_cmd_t    cmd;
  crb_sts_t    sts;
  logic [10:0] cap_r;
  logic [15:0] snap_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      snap_r <= SNAP_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_CAP:  cap_r  <= pwdata[10:0];
        REG_SNAP: snap_r <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CAP:  prdata = {21'b0, cap_r};
      REG_SNAP: prdata = {16'b0, snap_r};
      default:  prdata = '0;
    endcase
  end

  crb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  crb_dp #(
    .DEPTH         (DEPTH),
    .MAX_CONSUMERS (MAX_CONSUMERS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_op                 (in_op),
    .in_consumer_id        (in_consumer_id),
    .in_position           (in_position),
    .in_sequence_req       (in_sequence_req),
    .in_record_info        (in_record_info),
    .in_record_length      (in_record_length),
    .cfg_cap               (cap_r),
    .cfg_snap              (snap_r),
    .out_status            (out_status),
    .out_record_info_out   (out_record_info_out),
    .out_record_length_out (out_record_length_out),
    .out_record_sequence   (out_record_sequence),
    .out_assigned_consumer (out_assigned_consumer),
    .out_stored_count      (out_stored_count),
    .out_oldest_sequence   (out_oldest_sequence),
    .out_total_committed   (out_total_committed),
    .out_may_write         (out_may_write),
    .out_wake_mask         (out_wake_mask),
    .out_wakeups_sent      (out_wakeups_sent)
  );

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  import crb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 1024;
  localparam int MAX_CONSUMERS = 4;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  consumer_id;
    logic [9:0]  position;
    logic [63:0] sequence_req;
    logic [31:0] record_info;
    logic [15:0] record_length;
  } capture_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] record_info_out;
    logic [15:0] record_length_out;
    logic [63:0] record_sequence;
    logic [1:0]  assigned_consumer;
    logic [10:0] stored_count;
    logic [63:0] oldest_sequence;
    logic [63:0] total_committed;
    logic        may_write;
    logic [3:0]  wake_mask;
    logic [63:0] wakeups_sent;
  } ring_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic [1:0] in_consumer_id = '0;
  logic [9:0] in_position = '0;
  logic [63:0] in_sequence_req = '0;
  logic [31:0] in_record_info = '0;
  logic [15:0] in_record_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [31:0] out_record_info_out;
  logic [15:0] out_record_length_out;
  logic [63:0] out_record_sequence;
  logic [1:0] out_assigned_consumer;
  logic [10:0] out_stored_count;
  logic [63:0] out_oldest_sequence;
  logic [63:0] out_total_committed;
  logic out_may_write;
  logic [3:0] out_wake_mask;
  logic [63:0] out_wakeups_sent;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  capture_ring_buffer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_op(in_op), .in_consumer_id(in_consumer_id), .in_position(in_position),
    .in_sequence_req(in_sequence_req), .in_record_info(in_record_info),
    .in_record_length(in_record_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_record_info_out(out_record_info_out),
    .out_record_length_out(out_record_length_out),
    .out_record_sequence(out_record_sequence),
    .out_assigned_consumer(out_assigned_consumer),
    .out_stored_count(out_stored_count), .out_oldest_sequence(out_oldest_sequence),
    .out_total_committed(out_total_committed), .out_may_write(out_may_write),
    .out_wake_mask(out_wake_mask), .out_wakeups_sent(out_wakeups_sent),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow of the ring
  logic [31:0] shadow_info [DEPTH];
  logic [15:0] shadow_len [DEPTH];
  logic [63:0] shadow_tag [DEPTH];
  bit          shadow_written [DEPTH];
  logic [63:0] total_cnt;
  logic [63:0] floor_seq;
  int unsigned consumers;
  bit          waiting [MAX_CONSUMERS];
  bit          attached [MAX_CONSUMERS];
  logic [63:0] cons_pos [MAX_CONSUMERS];
  logic [63:0] wake_cnt;
  logic [10:0] cap_reg;
  logic [15:0] snap_reg;

  ring_status_t expected_status_q[$];
  int errors = 0;
  int results_seen = 0;
  int read_hits = 0;
  int read_misses = 0;
  int wake_results = 0;
  int stall_results = 0;
  bit quiet = 1'b0;

  function automatic logic [63:0] eff_cap();
    logic [63:0] c;
    c = {53'd0, cap_reg};
    if (c < 2) c = 2;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic logic [63:0] oldest_seq();
    logic [63:0] o;
    o = (total_cnt > eff_cap()) ? total_cnt - eff_cap() : 64'd0;
    return (floor_seq > o) ? floor_seq : o;
  endfunction

  function automatic logic [63:0] visible();
    return (oldest_seq() >= total_cnt) ? 64'd0 : total_cnt - oldest_seq();
  endfunction

  function automatic bit backpressure_free();
    for (int i = 0; i < consumers; i++) begin
      if (attached[i] && cons_pos[i] < total_cnt &&
          total_cnt - cons_pos[i] >= eff_cap() - 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit in_window(logic [63:0] s);
    return s >= oldest_seq() && s < total_cnt;
  endfunction

  function automatic bit slot_blank(logic [63:0] s);
    return in_window(s) && !shadow_written[s % eff_cap()];
  endfunction

  function automatic bit fetch_record(input logic [63:0] s, inout ring_status_t r);
    int slot;
    if (!in_window(s)) return 1'b0;
    slot = int'(s % eff_cap());
    if (!shadow_written[slot] || shadow_tag[slot] != s) return 1'b0;
    r.record_info_out = shadow_info[slot];
    r.record_length_out = (shadow_len[slot] > snap_reg) ? snap_reg : shadow_len[slot];
    r.record_sequence = s;
    return 1'b1;
  endfunction

  function automatic ring_status_t apply_request(capture_req_t q);
    ring_status_t r;
    int slot;
    bit present;
    r = '0;
    present = q.consumer_id < consumers;
    case (q.op)
      OP_COMMIT: begin
        slot = int'(total_cnt % eff_cap());
        shadow_info[slot] = q.record_info;
        shadow_len[slot] = q.record_length;
        shadow_tag[slot] = total_cnt;
        shadow_written[slot] = 1'b1;
        total_cnt++;
        for (int i = 0; i < consumers; i++) begin
          if (waiting[i]) begin
            waiting[i] = 1'b0;
            wake_cnt++;
            r.wake_mask[i] = 1'b1;
          end
        end
      end
      OP_READ_POS: begin
        if (q.position >= visible() || !fetch_record(oldest_seq() + q.position, r))
          r.status = ST_MISS;
      end
      OP_READ_SEQ: if (!fetch_record(q.sequence_req, r)) r.status = ST_MISS;
      OP_CLEAR: floor_seq = total_cnt;
      OP_ADD: begin
        if (consumers < MAX_CONSUMERS) begin
          r.assigned_consumer = consumers[1:0];
          consumers++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_ANNOUNCE: if (present) waiting[q.consumer_id] = 1'b1;
      OP_WITHDRAW: if (present) waiting[q.consumer_id] = 1'b0;
      OP_ATTACH: begin
        if (present) begin
          attached[q.consumer_id] = 1'b1;
          cons_pos[q.consumer_id] = '0;
        end
      end
      OP_PUBLISH: begin
        if (present) begin
          attached[q.consumer_id] = 1'b1;
          cons_pos[q.consumer_id] = q.sequence_req;
        end
      end
      default: ;
    endcase
    r.stored_count = 11'(visible());
    r.oldest_sequence = oldest_seq();
    r.total_committed = total_cnt;
    r.may_write = backpressure_free();
    r.wakeups_sent = wake_cnt;
    return r;
  endfunction

  task automatic send_request(capture_req_t q);
    if (!quiet && $urandom_range(99) < 24) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    // keep a read away from slots that were never filled
    if ((q.op == OP_READ_SEQ && slot_blank(q.sequence_req)) ||
        (q.op == OP_READ_POS && q.position < visible() &&
         slot_blank(oldest_seq() + q.position))) begin
      q.op = OP_READ_SEQ;
      q.sequence_req = total_cnt;
    end
    in_op = q.op;
    in_consumer_id = q.consumer_id;
    in_position = q.position;
    in_sequence_req = q.sequence_req;
    in_record_info = q.record_info;
    in_record_length = q.record_length;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_status_q.push_back(apply_request(q));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == 3'd0) cap_reg = data[10:0];
    else snap_reg = data[15:0];
  endtask

  task automatic drain();
    while (expected_status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(logic [10:0] cap, logic [15:0] snap);
    drain();
    write_reg(3'd0, {21'd0, cap});
    write_reg(3'd4, {16'd0, snap});
  endtask

  function automatic capture_req_t make_req(logic [3:0] op, logic [1:0] id = 0,
                                            logic [9:0] pos = 0, logic [63:0] s = 0,
                                            logic [31:0] info = 0, logic [15:0] len = 0);
    capture_req_t q;
    q.op = op;
    q.consumer_id = id;
    q.position = pos;
    q.sequence_req = s;
    q.record_info = info;
    q.record_length = len;
    return q;
  endfunction

  function automatic capture_req_t random_req();
    capture_req_t q;
    int pick;
    q.op = OP_COMMIT;
    q.consumer_id = 2'($urandom_range(3));
    q.position = 10'($urandom);
    q.sequence_req = {$urandom, $urandom};
    q.record_info = $urandom;
    q.record_length = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      q.op = OP_COMMIT;
    end else if (pick < 55) begin
      q.op = OP_READ_POS;
      if ($urandom_range(9) < 8)
        q.position = 10'($urandom_range((visible() > 1023) ? 1023 : visible() + 1));
    end else if (pick < 70) begin
      q.op = OP_READ_SEQ;
      if ($urandom_range(9) < 8) q.sequence_req = oldest_seq() - 1 + $urandom_range(visible() + 1);
    end else if (pick < 73) begin
      q.op = OP_CLEAR;
    end else if (pick < 75) begin
      q.op = OP_ADD;
    end else if (pick < 83) begin
      q.op = OP_ANNOUNCE;
    end else if (pick < 87) begin
      q.op = OP_WITHDRAW;
    end else if (pick < 90) begin
      q.op = OP_ATTACH;
    end else if (pick < 96) begin
      q.op = OP_PUBLISH;
      if ($urandom_range(9) < 8) q.sequence_req = total_cnt - $urandom_range(eff_cap());
    end else begin
      q.op = 4'($urandom_range(15, 9));
    end
    return q;
  endfunction

  task automatic test_directed();
    send_request(make_req(OP_READ_POS, 0, 0));
    send_request(make_req(OP_READ_SEQ, 0, 0, '1));
    send_request(make_req(OP_ANNOUNCE, 3));
    send_request(make_req(OP_ATTACH, 2));
    send_request(make_req(4'd15));
    send_request(make_req(4'd9));
    send_request(make_req(OP_COMMIT, 0, 0, 0, '1, '1));
    send_request(make_req(OP_ANNOUNCE, 0));
    send_request(make_req(OP_COMMIT, 0, 0, 0, 32'h0, 16'h0));
    send_request(make_req(OP_READ_POS, 0, 0));
    send_request(make_req(OP_READ_POS, 0, 1));
    send_request(make_req(OP_READ_POS, 0, '1));
    send_request(make_req(OP_READ_SEQ, 0, 0, 64'd1));
    repeat (4) send_request(make_req(OP_ADD));
    send_request(make_req(OP_ANNOUNCE, 1));
    send_request(make_req(OP_ANNOUNCE, 2));
    send_request(make_req(OP_ANNOUNCE, 3));
    send_request(make_req(OP_WITHDRAW, 2));
    send_request(make_req(OP_COMMIT, 0, 0, 0, 32'hA5A5_5A5A, 16'h1234));
    send_request(make_req(OP_ATTACH, 1));
    send_request(make_req(OP_PUBLISH, 2, 0, '1));
    send_request(make_req(OP_PUBLISH, 3, 0, 64'd0));
    send_request(make_req(OP_CLEAR));
    send_request(make_req(OP_READ_POS, 0, 0));
  endtask

  task automatic test_snap_clamp();
    configure(11'd1024, 16'd0);
    send_request(make_req(OP_COMMIT, 0, 0, 0, $urandom, 16'hFFFF));
    send_request(make_req(OP_READ_POS, 0, 0));
    configure(11'd1024, 16'd1);
    send_request(make_req(OP_READ_SEQ, 0, 0, total_cnt - 1));
  endtask

  task automatic test_random_phases();
    logic [10:0] caps [8] = '{11'd0, 11'd2, 11'd5, 11'd2047, 11'd37, 11'd1, 11'd1024, 11'd3};
    logic [15:0] snaps [8] = '{16'hFFFF, 16'd0, 16'd1, 16'd300, 16'hFFFF, 16'd4096,
                               16'd0, 16'd777};
    for (int ph = 0; ph < 8; ph++) begin
      configure(caps[ph], snaps[ph]);
      quiet = (ph == 4);
      repeat (135) send_request(random_req());
    end
    quiet = 1'b0;
  endtask

  always @(negedge clk) out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 24);

  always @(posedge clk) begin
    ring_status_t want;
    ring_status_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_record_info_out, out_record_length_out, out_record_sequence,
              out_assigned_consumer, out_stored_count, out_oldest_sequence,
              out_total_committed, out_may_write, out_wake_mask, out_wakeups_sent};
      results_seen++;
      if (expected_status_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = expected_status_q.pop_front();
        if (want.status == ST_MISS) read_misses++;
        if (want.record_sequence != 0 || want.record_info_out != 0) read_hits++;
        if (want.wake_mask != 0) wake_results++;
        if (!want.may_write) stall_results++;
        if (got.status != want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.record_info_out != want.record_info_out) begin
          $error("record_info_out exp %h got %h", want.record_info_out,
                 got.record_info_out); errors++;
        end
        if (got.record_length_out != want.record_length_out) begin
          $error("record_length_out exp %0d got %0d", want.record_length_out,
                 got.record_length_out); errors++;
        end
        if (got.record_sequence != want.record_sequence) begin
          $error("record_sequence exp %0d got %0d", want.record_sequence,
                 got.record_sequence); errors++;
        end
        if (got.assigned_consumer != want.assigned_consumer) begin
          $error("assigned_consumer exp %0d got %0d", want.assigned_consumer,
                 got.assigned_consumer); errors++;
        end
        if (got.stored_count != want.stored_count) begin
          $error("stored_count exp %0d got %0d", want.stored_count, got.stored_count);
          errors++;
        end
        if (got.oldest_sequence != want.oldest_sequence) begin
          $error("oldest_sequence exp %0d got %0d", want.oldest_sequence,
                 got.oldest_sequence); errors++;
        end
        if (got.total_committed != want.total_committed) begin
          $error("total_committed exp %0d got %0d", want.total_committed,
                 got.total_committed); errors++;
        end
        if (got.may_write != want.may_write) begin
          $error("may_write exp %0d got %0d", want.may_write, got.may_write); errors++;
        end
        if (got.wake_mask != want.wake_mask) begin
          $error("wake_mask exp %b got %b", want.wake_mask, got.wake_mask); errors++;
        end
        if (got.wakeups_sent != want.wakeups_sent) begin
          $error("wakeups_sent exp %0d got %0d", want.wakeups_sent, got.wakeups_sent);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("capture_ring_buffer regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) shadow_written[i] = 1'b0;
    for (int i = 0; i < MAX_CONSUMERS; i++) begin
      waiting[i] = 1'b0;
      attached[i] = 1'b0;
      cons_pos[i] = '0;
    end
    total_cnt = '0;
    floor_seq = '0;
    consumers = 1;
    wake_cnt = '0;
    cap_reg = CAP_RESET;
    snap_reg = SNAP_RESET;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_snap_clamp();
    test_random_phases();
    drain();
    $display("checked %0d result transactions over %0d commits", results_seen, total_cnt);
    $display("read hits %0d, misses %0d, wakes %0d, back-pressure %0d",
             read_hits, read_misses, wake_results, stall_results);
    if (errors == 0) begin
      $display("capture_ring_buffer regression: pass");
    end else begin
      $display("capture_ring_buffer regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
+incdir+src
src/crb_pkg.sv
src/crb_mod.sv
src/crb_ctrl.sv
src/crb_dp.sv
src/capture_ring_buffer.sv
tb/testbench.sv
